// File: hdl/nv21_to_argb_converter_top_macros.svh
// ----------------------------------------------------------------------------
// nv21 to argb converter assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef NV21_TO_ARGB_CONVERTER_TOP_MACROS_SVH
`define NV21_TO_ARGB_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define N2A_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define N2A_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define N2A_ASSERT_IMPLY(label, ante, cons)
`define N2A_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/n2a_pkg.sv
// ----------------------------------------------------------------------------
// n2a_pkg
// types, constants and helpers shared by the nv21 to argb converter
// ----------------------------------------------------------------------------
`default_nettype none

package n2a_pkg;

   localparam int DEF_MAX_DIMENSION = 4096;

   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [CSR_W-1:0] RESET_LINE_WIDTH   = 13'd640;
   localparam logic [CSR_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

   localparam logic [7:0] LUMA_OFFSET = 8'd16;
   localparam logic [7:0] ARGB_ALPHA  = 8'hff;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // product and sum widths of the color matrix
   localparam int YPROD_W = 19;
   localparam int CPROD_W = 20;
   localparam int SUM_W   = 22;

   localparam logic [YPROD_W-1:0]        COEF_Y  = 19'd1192;
   localparam logic signed [CPROD_W-1:0] COEF_RV = 20'sd1634;
   localparam logic signed [CPROD_W-1:0] COEF_GV = 20'sd833;
   localparam logic signed [CPROD_W-1:0] COEF_GU = 20'sd400;
   localparam logic signed [CPROD_W-1:0] COEF_BU = 20'sd2066;
   localparam logic signed [SUM_W-1:0]   CHAN_MAX = 22'sd262143;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_v;
      logic [7:0] chroma_u;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic        end_of_line;
      logic        end_of_frame;
   } rsp_type;

   // classified pixel handed from front to back
   typedef struct packed {
      logic [7:0]        y;
      logic signed [8:0] v;
      logic signed [8:0] u;
      logic              eol;
      logic              eof;
   } work_type;

   function automatic logic [7:0] chan_byte(input logic signed [SUM_W-1:0] x);
      logic [7:0] res;
      if (x < 0) begin
         res = 8'd0;
      end else if (x > CHAN_MAX) begin
         res = 8'hff;
      end else begin
         res = x[17:10];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hdl/nv21_to_argb_converter_top.sv
// ----------------------------------------------------------------------------
// nv21_to_argb_converter_top
// nv21 pixel stream to opaque argb pixel stream
// ----------------------------------------------------------------------------
// Takes one pixel word per clock in raster order while req_ready is high, and
// returns one packed argb word per pixel, one word per clock while rsp_ready
// holds. An accepted pixel is registered in the queue, then in the product stage; the front
// (counters, chroma hold) feeds a four-word queue, and the back runs the
// matrix as a product stage followed by a sum/saturate stage into the output
// register. Config writes (csr_ready is always high) should be made while the
// stream is idle; line_width and frame_height of zero count as one, and
// values above MAX_DIMENSION count as MAX_DIMENSION.
`default_nettype none

module nv21_to_argb_converter_top import n2a_pkg::*; #(
   parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   logic     push, queue_full, pop_valid, pop;
   work_type push_data, pop_data;

   assign csr_ready = 1'b1;

   n2a_front #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   n2a_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   n2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_ready  (pop),
      .in_data   (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hdl/n2a_front.sv
// ----------------------------------------------------------------------------
// n2a_front
// config registers, raster counters, chroma hold and luma offset
// ----------------------------------------------------------------------------
`default_nettype none

`include "nv21_to_argb_converter_top_macros.svh"

module n2a_front import n2a_pkg::*; #(
   parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire logic                 queue_full,
   output logic                      push,
   output work_type                  push_data
);

   localparam int CNT_W = $clog2(MAX_DIMENSION);
   localparam int CMP_W = (CSR_W > CNT_W + 1) ? CSR_W : CNT_W + 1;

   logic [CSR_W-1:0] line_width_ff, frame_height_ff;
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic signed [8:0] held_v_ff, held_u_ff, new_v, new_u;
   logic [CNT_W-1:0] width_m1, height_m1;
   logic [CMP_W-1:0] w_ext, h_ext, max_ext;
   logic [8:0]       luma_diff;
   logic             eol, eof, even;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= RESET_LINE_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective dimension minus one: zero reads as one, oversize as the maximum
   always_comb begin
      w_ext   = CMP_W'(line_width_ff);
      h_ext   = CMP_W'(frame_height_ff);
      max_ext = CMP_W'(MAX_DIMENSION);
      priority if (w_ext == '0) begin
         width_m1 = '0;
      end else if (w_ext > max_ext) begin
         width_m1 = CNT_W'(MAX_DIMENSION - 1);
      end else begin
         width_m1 = CNT_W'(w_ext - CMP_W'(1));
      end
      priority if (h_ext == '0) begin
         height_m1 = '0;
      end else if (h_ext > max_ext) begin
         height_m1 = CNT_W'(MAX_DIMENSION - 1);
      end else begin
         height_m1 = CNT_W'(h_ext - CMP_W'(1));
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   assign eol  = col_ff >= width_m1;
   assign eof  = eol && (row_ff >= height_m1);
   assign even = !col_ff[0];

   // chroma minus 128 is the byte with its top bit flipped, sign extended
   assign new_v = $signed({~req_data.chroma_v[7], ~req_data.chroma_v[7],
                           req_data.chroma_v[6:0]});
   assign new_u = $signed({~req_data.chroma_u[7], ~req_data.chroma_u[7],
                           req_data.chroma_u[6:0]});

   assign luma_diff = {1'b0, req_data.luma} - {1'b0, LUMA_OFFSET};

   always_comb begin
      push_data.y   = luma_diff[8] ? 8'd0 : luma_diff[7:0];
      push_data.v   = even ? new_v : held_v_ff;
      push_data.u   = even ? new_u : held_u_ff;
      push_data.eol = eol;
      push_data.eof = eof;
      if (eol) begin
         col_in = '0;
         row_in = eof ? '0 : row_ff + CNT_W'(1);
      end else begin
         col_in = col_ff + CNT_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         held_v_ff <= '0;
         held_u_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (even) begin
            held_v_ff <= new_v;
            held_u_ff <= new_u;
         end
      end
   end

   `N2A_ASSERT_IMPLY(a_eof_in_eol, push && push_data.eof, push_data.eol)
   `N2A_ASSERT_NEXT(a_eol_wraps_col, push && eol, col_ff == '0)

endmodule

`default_nettype wire

// File: hdl/n2a_queue.sv
// ----------------------------------------------------------------------------
// n2a_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "nv21_to_argb_converter_top_macros.svh"

module n2a_queue import n2a_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   output logic          pop_valid,
   input  wire logic     pop,
   output work_type      pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full      = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      unique case ({push, do_pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   `N2A_ASSERT_IMPLY(a_no_overflow, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH))
   `N2A_ASSERT_IMPLY(a_no_push_full, push, !full)

endmodule

`default_nettype wire

// File: hdl/n2a_back.sv
// ----------------------------------------------------------------------------
// n2a_back
// two-stage color matrix: products, then sums, saturation and packing
// ----------------------------------------------------------------------------
`default_nettype none

`include "nv21_to_argb_converter_top_macros.svh"

module n2a_back import n2a_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire work_type in_data,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic                       s1_valid_ff, rsp_valid_ff;
   logic [YPROD_W-1:0]         ys_ff;
   logic signed [CPROD_W-1:0]  rv_ff, gv_ff, gu_ff, bu_ff;
   logic                       eol_ff, eof_ff;
   rsp_type                    rsp_ff, rsp_in;
   logic signed [SUM_W-1:0]    ys_s, r_sum, g_sum, b_sum;
   logic                       s1_ready, s2_ready;

   assign s2_ready = !rsp_valid_ff || rsp_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: one product per coefficient
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         ys_ff  <= COEF_Y * YPROD_W'(in_data.y);
         rv_ff  <= COEF_RV * CPROD_W'(in_data.v);
         gv_ff  <= COEF_GV * CPROD_W'(in_data.v);
         gu_ff  <= COEF_GU * CPROD_W'(in_data.u);
         bu_ff  <= COEF_BU * CPROD_W'(in_data.u);
         eol_ff <= in_data.eol;
         eof_ff <= in_data.eof;
      end
   end

   // stage 2: sums and saturation
   always_comb begin
      ys_s  = SUM_W'($signed({1'b0, ys_ff}));
      r_sum = ys_s + SUM_W'(rv_ff);
      g_sum = ys_s - SUM_W'(gv_ff) - SUM_W'(gu_ff);
      b_sum = ys_s + SUM_W'(bu_ff);
      rsp_in.pixel_argb   = {ARGB_ALPHA, chan_byte(r_sum), chan_byte(g_sum),
                             chan_byte(b_sum)};
      rsp_in.end_of_line  = eol_ff;
      rsp_in.end_of_frame = eof_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `N2A_ASSERT_IMPLY(a_alpha_opaque, rsp_valid_ff, rsp_ff.pixel_argb[31:24] == ARGB_ALPHA)
   `N2A_ASSERT_NEXT(a_s1_holds, s1_valid_ff && !s2_ready, s1_valid_ff && $stable(ys_ff))

endmodule

`default_nettype wire
